FILE: rtl/qmp_pkg.sv
package qmp_pkg;

  localparam int DEF_MAX_QUBITS = 10;
  localparam int NUMQ_W = 4;
  localparam int QUBIT_W = 4;
  localparam int AMP_W = 16;
  localparam int SQ_W = 31;
  localparam int PROB_W = 32;
  localparam int PROBZ_W = 33;

  localparam logic [NUMQ_W-1:0] RESET_NUM_QUBITS = 4'd2;
  localparam logic [PROBZ_W-1:0] ONE_Q230 = 33'h0_4000_0000;
  localparam logic [PROB_W-1:0] PROB_SAT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic amp_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/qmp_ctrl.sv
module qmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qmp_pkg::dp_status_t status,
  output qmp_pkg::ctrl_cmd_t  cmd
);

  qmp_pkg::state_t state;
  qmp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qmp_pkg::ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      qmp_pkg::ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.amp_last) begin
          state_next = qmp_pkg::ST_DRAIN;
        end
      end
      qmp_pkg::ST_DRAIN: begin
        state_next = qmp_pkg::ST_EMIT;
      end
      qmp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            cmd.clear = 1'b1;
            state_next = qmp_pkg::ST_ACCUM;
          end
        end
      end
      default: begin
        state_next = qmp_pkg::ST_ACCUM;
      end
    endcase
  end

  a_drain_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == qmp_pkg::ST_DRAIN |=> state == qmp_pkg::ST_EMIT)
    else $error("drain cycle not followed by emission");

  a_no_accept_outside_accum: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> state == qmp_pkg::ST_ACCUM)
    else $error("transaction accepted while not accumulating");

  a_clear_only_on_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> cmd.emit && status.emit_last)
    else $error("accumulators cleared before the final result");

endmodule

FILE: rtl/qmp_datapath.sv
module qmp_datapath #(
  parameter int MAX_QUBITS = qmp_pkg::DEF_MAX_QUBITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [qmp_pkg::NUMQ_W-1:0]         cfg_wdata,
  input  logic signed [qmp_pkg::AMP_W-1:0]   amp_real,
  input  logic signed [qmp_pkg::AMP_W-1:0]   amp_imag,
  input  qmp_pkg::ctrl_cmd_t                 cmd,
  output qmp_pkg::dp_status_t                status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [qmp_pkg::QUBIT_W-1:0]        qubit,
  output logic [qmp_pkg::PROB_W-1:0]         prob_one,
  output logic signed [qmp_pkg::PROBZ_W-1:0] prob_zero,
  output logic                               last
);

  localparam int NW = $clog2(MAX_QUBITS + 1);
  localparam int AW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam logic [4:0] MAX5 = 5'(MAX_QUBITS);

  logic [qmp_pkg::NUMQ_W-1:0] num_qubits;
  logic [4:0]                 eff5;
  logic [NW-1:0]              eff_n;
  logic [MAX_QUBITS-1:0]      amp_count;
  logic [MAX_QUBITS-1:0]      low_mask;
  logic [MAX_QUBITS-1:0]      aligned;
  logic [MAX_QUBITS-1:0]      hit;
  logic [MAX_QUBITS-1:0]      hit_vec;
  logic                       s1_valid;
  logic [qmp_pkg::SQ_W-1:0]   sq_re;
  logic [qmp_pkg::SQ_W-1:0]   sq_im;
  logic signed [31:0]         prod_re;
  logic signed [31:0]         prod_im;
  logic [qmp_pkg::PROB_W-1:0] mag;
  logic [qmp_pkg::PROB_W-1:0] prob_acc [MAX_QUBITS];
  logic [AW-1:0]              q_cnt;
  logic [qmp_pkg::PROB_W-1:0] sel_acc;

  always_comb begin
    eff5 = {1'b0, num_qubits};
    if (eff5 == 5'd0) begin
      eff5 = 5'd1;
    end else if (eff5 > MAX5) begin
      eff5 = MAX5;
    end
  end

  assign eff_n = NW'(eff5);
  assign low_mask = ~({MAX_QUBITS{1'b1}} << eff_n);
  assign aligned = amp_count << (NW'(MAX_QUBITS) - eff_n);

  always_comb begin
    for (int q = 0; q < MAX_QUBITS; q++) begin
      hit[q] = aligned[MAX_QUBITS-1-q];
    end
  end

  assign prod_re = amp_real * amp_real;
  assign prod_im = amp_imag * amp_imag;
  assign mag = {1'b0, sq_re} + {1'b0, sq_im};

  assign sel_acc = prob_acc[q_cnt];

  assign status.amp_last = (amp_count == low_mask);
  assign status.emit_last = (q_cnt == AW'(eff_n - NW'(1)));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_qubits <= qmp_pkg::RESET_NUM_QUBITS;
    end else if (cfg_we) begin
      num_qubits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we || cmd.clear) begin
      amp_count <= '0;
    end else if (cmd.accept) begin
      if (status.amp_last) begin
        amp_count <= '0;
      end else begin
        amp_count <= amp_count + MAX_QUBITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_re <= qmp_pkg::SQ_W'(prod_re);
      sq_im <= qmp_pkg::SQ_W'(prod_im);
      hit_vec <= hit;
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < MAX_QUBITS; q++) begin
      if (rst || cfg_we || cmd.clear) begin
        prob_acc[q] <= '0;
      end else if (s1_valid && hit_vec[q]) begin
        if ({1'b0, prob_acc[q]} + {1'b0, mag} > {1'b0, qmp_pkg::PROB_SAT}) begin
          prob_acc[q] <= qmp_pkg::PROB_SAT;
        end else begin
          prob_acc[q] <= prob_acc[q] + mag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      q_cnt <= '0;
    end else if (cmd.emit) begin
      q_cnt <= q_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      qubit <= qmp_pkg::QUBIT_W'(q_cnt);
      prob_one <= sel_acc;
      prob_zero <= $signed(qmp_pkg::ONE_Q230 - {1'b0, sel_acc});
      last <= status.emit_last;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (amp_count & ~low_mask) == '0)
    else $error("amplitude count beyond vector length");

  a_clear_empties_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> prob_acc[0] == '0 && amp_count == '0)
    else $error("accumulators not cleared after final result");

  a_no_update_during_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !s1_valid)
    else $error("accumulator update pending during emission");

endmodule

FILE: rtl/qubit_marginal_probability_core.sv
// Output: after the last amplitude of a vector is accepted, the controller passes
// through its drain and emit states, and results leave through the output register,
// one result per cycle while out_ready is high. Input: one amplitude per cycle, but
// in_ready is low during the multiply-stage drain and the per-qubit result readout.
// Reset: synchronous; num_qubits returns to 2, the amplitude count and all
// accumulators clear, and no result is pending.
module qubit_marginal_probability_core #(
  parameter int MAX_QUBITS = qmp_pkg::DEF_MAX_QUBITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [qmp_pkg::NUMQ_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qmp_pkg::AMP_W-1:0]   amp_real,
  input  logic signed [qmp_pkg::AMP_W-1:0]   amp_imag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [qmp_pkg::QUBIT_W-1:0]        qubit,
  output logic [qmp_pkg::PROB_W-1:0]         prob_one,
  output logic signed [qmp_pkg::PROBZ_W-1:0] prob_zero,
  output logic                               last
);

  qmp_pkg::ctrl_cmd_t  cmd;
  qmp_pkg::dp_status_t status;

  qmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qmp_datapath #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .amp_real  (amp_real),
    .amp_imag  (amp_imag),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .qubit     (qubit),
    .prob_one  (prob_one),
    .prob_zero (prob_zero),
    .last      (last)
  );

endmodule
